@@ sv/priority_task_queue_macros.svh @@
// ---------------------------------------------------------------------------
// priority_task_queue_macros: assertion macros
// Clocked, reset-qualified implication checks used by the priority_task_queue RTL.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_TASK_QUEUE_MACROS_SVH
`define PRIORITY_TASK_QUEUE_MACROS_SVH

// Same-cycle implication
`define PTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define PTQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ptq_pkg.sv @@
// ---------------------------------------------------------------------------
// ptq_pkg: shared definitions of the priority task queue
// Sizes, command and status codes, and the structs passed along the chain.
// ---------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int TAG_BITS      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POP    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Command broadcast to every cell
    typedef struct packed {
        logic                     go;
        t_op                      op;
        logic [PRIORITY_BITS-1:0] pri;
        logic [TAG_BITS-1:0]      tag;
    } t_cmd;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        logic                     valid;
        logic [PRIORITY_BITS-1:0] pri;
        logic [TAG_BITS-1:0]      tag;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/ptq_cell.sv @@
// ---------------------------------------------------------------------------
// ptq_cell: one slot of the sorted queue
// Holds one task; on a command it keeps, takes the new task, takes the
// contents of its left or right neighbor, or is cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module ptq_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ptq_pkg::t_cmd        i_cmd,
    input  wire ptq_pkg::t_entry      i_left,
    input  wire logic                 i_left_ge,
    input  wire ptq_pkg::t_entry      i_right,
    input  wire logic                 i_hit,
    output ptq_pkg::t_entry           o_entry,
    output logic                      o_ge,
    output logic                      o_hit
);

    logic                              r_valid;
    logic [ptq_pkg::PRIORITY_BITS-1:0] r_pri;
    logic [ptq_pkg::TAG_BITS-1:0]      r_tag;
    logic                              n_valid;
    logic [ptq_pkg::PRIORITY_BITS-1:0] n_pri;
    logic [ptq_pkg::TAG_BITS-1:0]      n_tag;
    logic                              w_match;

    // Local compares: stays ahead of the new task, holds the searched tag
    assign o_ge    = r_valid && (r_pri >= i_cmd.pri);
    assign w_match = r_valid && (r_tag == i_cmd.tag);
    assign o_hit   = i_hit || w_match;

    assign o_entry.valid = r_valid;
    assign o_entry.pri   = r_pri;
    assign o_entry.tag   = r_tag;

    // Next contents
    always_comb begin
        n_valid = r_valid;
        n_pri   = r_pri;
        n_tag   = r_tag;
        if (i_cmd.go) begin
            case (i_cmd.op)
                ptq_pkg::OP_INSERT: begin
                    if (!o_ge) begin
                        if (i_left_ge) begin
                            // first slot behind the equal or higher priorities
                            n_valid = 1'b1;
                            n_pri   = i_cmd.pri;
                            n_tag   = i_cmd.tag;
                        end else begin
                            n_valid = i_left.valid;
                            n_pri   = i_left.pri;
                            n_tag   = i_left.tag;
                        end
                    end
                end
                ptq_pkg::OP_REMOVE: begin
                    // at or behind the first match: close the gap
                    if (o_hit) begin
                        n_valid = i_right.valid;
                        n_pri   = i_right.pri;
                        n_tag   = i_right.tag;
                    end
                end
                ptq_pkg::OP_POP: begin
                    n_valid = i_right.valid;
                    n_pri   = i_right.pri;
                    n_tag   = i_right.tag;
                end
                ptq_pkg::OP_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    // Slot registers; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_pri <= n_pri;
        r_tag <= n_tag;
    end

endmodule

`default_nettype wire

@@ sv/priority_task_queue.sv @@
// ---------------------------------------------------------------------------
// priority_task_queue: sorted priority queue of tasks
// Insert, remove by id, pop head and clear on a chain of slot cells.
// ---------------------------------------------------------------------------
// Each command is captured in the transfer cycle, and in the
// next cycle every cell of the chain updates at once (compare against the
// new priority or tag, then shift by one slot) while the result register is
// loaded. A new command is taken once that result has been taken or in the
// cycle it is taken, but not while a command is executing. The result
// register is the only output storage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "priority_task_queue_macros.svh"

module priority_task_queue (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_op,
    input  wire logic [ptq_pkg::PRIORITY_BITS-1:0] i_priority_req,
    input  wire logic [ptq_pkg::TAG_BITS-1:0]      i_task_id,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [1:0]                             o_status,
    output logic [ptq_pkg::TAG_BITS-1:0]           o_head_id,
    output logic [ptq_pkg::PRIORITY_BITS-1:0]      o_head_priority,
    output logic [ptq_pkg::COUNT_BITS-1:0]         o_count
);

    logic                              r_busy;
    ptq_pkg::t_op                      r_op;
    logic [ptq_pkg::PRIORITY_BITS-1:0] r_pri;
    logic [ptq_pkg::TAG_BITS-1:0]      r_tag;
    logic                              r_out_valid;
    ptq_pkg::t_status                  r_status;
    logic [ptq_pkg::TAG_BITS-1:0]      r_head_id;
    logic [ptq_pkg::PRIORITY_BITS-1:0] r_head_pri;
    logic [ptq_pkg::COUNT_BITS-1:0]    r_count;
    ptq_pkg::t_status                  n_status;
    logic [ptq_pkg::TAG_BITS-1:0]      n_head_id;
    logic [ptq_pkg::PRIORITY_BITS-1:0] n_head_pri;
    logic [ptq_pkg::COUNT_BITS-1:0]    n_count;
    logic                              w_accept;
    logic                              w_full;
    logic                              w_empty;
    logic                              w_found;
    ptq_pkg::t_cmd                     w_cmd;
    ptq_pkg::t_entry                   w_ent [ptq_pkg::QUEUE_DEPTH+2];
    logic                              w_ge  [ptq_pkg::QUEUE_DEPTH+1];
    logic                              w_hit [ptq_pkg::QUEUE_DEPTH+1];
    logic [ptq_pkg::QUEUE_DEPTH-1:0]   w_valid_vec;

    // Input handshake
    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Queue status from the chain ends
    assign w_full  = w_ent[ptq_pkg::QUEUE_DEPTH].valid;
    assign w_empty = !w_ent[1].valid;
    assign w_found = w_hit[ptq_pkg::QUEUE_DEPTH];

    // Command broadcast; an insert into a full queue is dropped
    assign w_cmd.go  = r_busy && !((r_op == ptq_pkg::OP_INSERT) && w_full);
    assign w_cmd.op  = r_op;
    assign w_cmd.pri = r_pri;
    assign w_cmd.tag = r_tag;

    // Chain boundaries
    assign w_ent[0]                      = '0;
    assign w_ent[ptq_pkg::QUEUE_DEPTH+1] = '0;
    assign w_ge[0]                       = 1'b1;
    assign w_hit[0]                      = 1'b0;

    // Cell chain, slot 0 is the head
    for (genvar g = 0; g < ptq_pkg::QUEUE_DEPTH; g++) begin : g_cell
        ptq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_left    (w_ent[g]),
            .i_left_ge (w_ge[g]),
            .i_right   (w_ent[g+2]),
            .i_hit     (w_hit[g]),
            .o_entry   (w_ent[g+1]),
            .o_ge      (w_ge[g+1]),
            .o_hit     (w_hit[g+1])
        );
        assign w_valid_vec[g] = w_ent[g+1].valid;
    end

    // Result of the executing command
    always_comb begin
        n_status   = ptq_pkg::ST_OK;
        n_head_id  = '0;
        n_head_pri = '0;
        n_count    = r_count;
        case (r_op)
            ptq_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = ptq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + ptq_pkg::COUNT_BITS'(1);
                end
            end
            ptq_pkg::OP_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - ptq_pkg::COUNT_BITS'(1);
                end else begin
                    n_status = ptq_pkg::ST_NOT_FOUND;
                end
            end
            ptq_pkg::OP_POP: begin
                if (w_empty) begin
                    n_status = ptq_pkg::ST_EMPTY;
                end else begin
                    n_head_id  = w_ent[1].tag;
                    n_head_pri = w_ent[1].pri;
                    n_count    = r_count - ptq_pkg::COUNT_BITS'(1);
                end
            end
            ptq_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_status = ptq_pkg::ST_OK;
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_busy <= w_accept;
            if (r_busy) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_op  <= ptq_pkg::t_op'(i_op);
            r_pri <= i_priority_req;
            r_tag <= i_task_id;
        end
        if (r_busy) begin
            r_status   <= n_status;
            r_head_id  <= n_head_id;
            r_head_pri <= n_head_pri;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_head_id       = r_head_id;
    assign o_head_priority = r_head_pri;
    assign o_count         = r_count;

    // Checks
    `PTQ_ASSERT_NXT(a_exec_one_cycle, r_busy, !r_busy && r_out_valid, "command not completed")
    `PTQ_ASSERT_IMP(a_count_matches, !r_busy, r_count == ptq_pkg::COUNT_BITS'($countones(w_valid_vec)), "count mismatch")
    `PTQ_ASSERT_IMP(a_valid_prefix, 1'b1, ((w_valid_vec + ptq_pkg::QUEUE_DEPTH'(1)) & w_valid_vec) == '0, "gap in queue")
    `PTQ_ASSERT_IMP(a_no_accept_busy, r_busy, !w_accept, "transfer during execution")

endmodule

`default_nettype wire
